### sv/peer_penalty_ban_table_macros.svh
// Assertion macros for the peer penalty ban table.
// Included by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef PEER_PENALTY_BAN_TABLE_MACROS_SVH
`define PEER_PENALTY_BAN_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define PPBT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PPBT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PPBT_ASSERT(lbl, prop, msg)
`define PPBT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/ppbt_pkg.sv
// Shared types and constants for the peer penalty ban table.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ppbt_pkg;

    // Field widths of the channels.
    localparam int CMD_W      = 2;
    localparam int KEY_W      = 64;
    localparam int NOW_W      = 48;
    localparam int END_W      = 49;
    localparam int CNT_W      = 4;
    localparam int REM_W      = 7;
    localparam int MIN_W      = 16;
    localparam int PROD_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default table depth.
    localparam int ENTRIES_DEF = 64;

    // Milliseconds in one minute.
    localparam logic [PROD_W-1:0] MS_PER_MIN = 32'd60000;

    // Register reset values.
    localparam logic [MIN_W-1:0] BASE_RST = 16'd5;
    localparam logic [MIN_W-1:0] MAX_RST  = 16'd1440;
    localparam logic [CNT_W-1:0] CAP_RST  = 4'd10;

    // Saturation point of the removed count.
    localparam logic [REM_W-1:0] REM_SAT = 7'd127;

    // Commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_STRIKE = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_SWEEP  = 2'd2
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE = 2'd0,
        REG_MAX  = 2'd1,
        REG_CAP  = 2'd2
    } t_reg;

    // One table entry as stored in memory.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] strikes;
        logic [END_W-1:0] end_ms;
    } t_entry;

endpackage

`default_nettype wire

### sv/ppbt_ifs.sv
// Valid/ready channel interfaces of the peer penalty ban table.
// Depends on ppbt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Command channel.
interface ppbt_in_if;
    import ppbt_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] peer_key;
    logic [NOW_W-1:0] now_ms;
    modport source (output valid, cmd, peer_key, now_ms, input ready);
    modport sink   (input valid, cmd, peer_key, now_ms, output ready);
endinterface

// Result channel.
interface ppbt_out_if;
    import ppbt_pkg::*;
    logic             valid;
    logic             ready;
    logic             banned;
    logic [CNT_W-1:0] strike_count;
    logic [END_W-1:0] ban_end_ms;
    logic [REM_W-1:0] removed;
    logic             status;
    modport source (output valid, banned, strike_count, ban_end_ms, removed, status,
                    input ready);
    modport sink   (input valid, banned, strike_count, ban_end_ms, removed, status,
                    output ready);
endinterface

// Configuration write channel.
interface ppbt_cfg_if;
    import ppbt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

### sv/peer_penalty_ban_table.sv
// Peer penalty ban table: a query or sweep reads every entry in one scan; a strike scans,
// then doubles the ban once per strike after the first and writes the entry back.
// One command is in flight at a time; the next is taken only once its result has entered
// the output register.
// After reset a clearing pass writes every entry invalid before
// the first command is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "peer_penalty_ban_table_macros.svh"

module peer_penalty_ban_table #(
    parameter int ENTRIES = ppbt_pkg::ENTRIES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ppbt_in_if.sink     i_in,
    ppbt_out_if.source  o_out,
    ppbt_cfg_if.sink    i_cfg
);
    import ppbt_pkg::*;

    localparam int               IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(ENTRIES - 1);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_SCAN  = 8'b00000100,
        ST_PREP  = 8'b00001000,
        ST_BAN   = 8'b00010000,
        ST_MUL   = 8'b00100000,
        ST_ADD   = 8'b01000000,
        ST_DONE  = 8'b10000000
    } t_state;

    // Table memory and its registered read data.
    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    // Configuration registers.
    logic [MIN_W-1:0] r_base;
    logic [MIN_W-1:0] r_max;
    logic [CNT_W-1:0] r_cap;

    // Sequencer state.
    t_state           r_state,      n_state;
    logic [IDX_W-1:0] r_addr,       n_addr;
    logic             r_issue_done, n_issue_done;
    logic             r_pv,         n_pv;
    logic [IDX_W-1:0] r_paddr,      n_paddr;
    t_cmd             r_cmd,        n_cmd;
    logic [KEY_W-1:0] r_key,        n_key;
    logic [NOW_W-1:0] r_now,        n_now;
    logic             r_hit,        n_hit;
    logic [IDX_W-1:0] r_hit_addr,   n_hit_addr;
    logic             r_free_found, n_free_found;
    logic [IDX_W-1:0] r_free_addr,  n_free_addr;
    logic [IDX_W-1:0] r_slot,       n_slot;
    logic [REM_W-1:0] r_removed,    n_removed;
    logic             r_status,     n_status;
    logic [CNT_W-1:0] r_res_cnt,    n_res_cnt;
    logic [END_W-1:0] r_res_end,    n_res_end;
    logic [MIN_W-1:0] r_m,          n_m;
    logic [CNT_W-1:0] r_iter,       n_iter;
    logic [PROD_W-1:0] r_prod,      n_prod;

    // Output register.
    logic             r_o_valid,    n_o_valid;
    logic             r_o_banned;
    logic [CNT_W-1:0] r_o_cnt;
    logic [END_W-1:0] r_o_end;
    logic [REM_W-1:0] r_o_removed;
    logic             r_o_status;

    // Memory write port.
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    logic             in_fire;
    logic             out_load;
    logic [CNT_W:0]   inc_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic [MIN_W:0]   dbl_m;
    logic [END_W-1:0] sum_end;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && (r_state == ST_IDLE);

    assign o_out.valid        = r_o_valid;
    assign o_out.banned       = r_o_banned;
    assign o_out.strike_count = r_o_cnt;
    assign o_out.ban_end_ms   = r_o_end;
    assign o_out.removed      = r_o_removed;
    assign o_out.status       = r_o_status;

    // Strike count after this strike, saturated at the cap.
    assign inc_cnt = {1'b0, r_res_cnt} + (CNT_W + 1)'(1);
    assign new_cnt = (inc_cnt > {1'b0, r_cap}) ? r_cap : inc_cnt[CNT_W-1:0];

    // Shared datapath: one doubling, the ban end sum.
    assign dbl_m   = {r_m, 1'b0};
    assign sum_end = END_W'(r_now) + END_W'(r_prod);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RST;
            r_max  <= MAX_RST;
            r_cap  <= CAP_RST;
        end else if (i_cfg.valid) begin
            case (t_reg'(i_cfg.idx))
                REG_BASE: r_base <= i_cfg.data;
                REG_MAX:  r_max  <= i_cfg.data;
                REG_CAP:  r_cap  <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_pv         = r_pv;
        n_paddr      = r_paddr;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_now        = r_now;
        n_hit        = r_hit;
        n_hit_addr   = r_hit_addr;
        n_free_found = r_free_found;
        n_free_addr  = r_free_addr;
        n_slot       = r_slot;
        n_removed    = r_removed;
        n_status     = r_status;
        n_res_cnt    = r_res_cnt;
        n_res_end    = r_res_end;
        n_m          = r_m;
        n_iter       = r_iter;
        n_prod       = r_prod;
        n_o_valid    = r_o_valid;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        wr_addr      = r_addr;
        wr_data      = '0;

        // A waiting result leaves when the sink takes it.
        if (o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            // Write every entry invalid after reset.
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end

            // Take a command and start the scan from entry zero.
            ST_IDLE: begin
                if (in_fire) begin
                    n_cmd        = t_cmd'(i_in.cmd);
                    n_key        = i_in.peer_key;
                    n_now        = i_in.now_ms;
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    n_pv         = 1'b0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_removed    = '0;
                    n_status     = 1'b0;
                    n_res_cnt    = '0;
                    n_res_end    = '0;
                    case (t_cmd'(i_in.cmd))
                        CMD_STRIKE, CMD_QUERY, CMD_SWEEP: n_state = ST_SCAN;
                        default:                          n_state = ST_DONE;
                    endcase
                end
            end

            // Issue one read per cycle; check the entry read the cycle before.
            ST_SCAN: begin
                n_pv    = !r_issue_done;
                n_paddr = r_addr;
                if (!r_issue_done) begin
                    if (r_addr == LAST) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end
                if (r_pv) begin
                    if (r_cmd == CMD_SWEEP) begin
                        if (r_rd_data.valid && (r_rd_data.end_ms <= {1'b0, r_now})) begin
                            mem_we        = 1'b1;
                            wr_addr       = r_paddr;
                            wr_data       = r_rd_data;
                            wr_data.valid = 1'b0;
                            if (r_removed != REM_SAT) begin
                                n_removed = r_removed + REM_W'(1);
                            end
                        end
                    end else begin
                        if (r_rd_data.valid && (r_rd_data.key == r_key)) begin
                            n_hit      = 1'b1;
                            n_hit_addr = r_paddr;
                            n_res_cnt  = r_rd_data.strikes;
                            n_res_end  = r_rd_data.end_ms;
                        end else if (!r_rd_data.valid && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_addr  = r_paddr;
                        end
                    end
                    if (r_paddr == LAST) begin
                        n_state = (r_cmd == CMD_STRIKE) ? ST_PREP : ST_DONE;
                    end
                end
            end

            // Pick the slot and the new count, or drop the strike on a full table.
            ST_PREP: begin
                if (!r_hit && !r_free_found) begin
                    n_status = 1'b1;
                    n_state  = ST_DONE;
                end else begin
                    n_slot    = r_hit ? r_hit_addr : r_free_addr;
                    n_res_cnt = new_cnt;
                    n_m       = r_base;
                    n_iter    = (new_cnt > CNT_W'(1)) ? (new_cnt - CNT_W'(1)) : '0;
                    n_state   = ST_BAN;
                end
            end

            // One capped doubling of the ban length per cycle.
            ST_BAN: begin
                if (r_iter != '0) begin
                    n_m    = (dbl_m > {1'b0, r_max}) ? r_max : dbl_m[MIN_W-1:0];
                    n_iter = r_iter - CNT_W'(1);
                end else begin
                    n_state = ST_MUL;
                end
            end

            // Minutes to milliseconds.
            ST_MUL: begin
                n_prod  = PROD_W'(r_m) * MS_PER_MIN;
                n_state = ST_ADD;
            end

            // Ban end and entry write-back.
            ST_ADD: begin
                mem_we          = 1'b1;
                wr_addr         = r_slot;
                wr_data.valid   = 1'b1;
                wr_data.key     = r_key;
                wr_data.strikes = r_res_cnt;
                wr_data.end_ms  = sum_end;
                n_res_end       = sum_end;
                n_state         = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    out_load  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pv         <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_pv         <= n_pv;
            r_o_valid    <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_paddr      <= n_paddr;
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_now        <= n_now;
        r_hit        <= n_hit;
        r_hit_addr   <= n_hit_addr;
        r_free_found <= n_free_found;
        r_free_addr  <= n_free_addr;
        r_slot       <= n_slot;
        r_removed    <= n_removed;
        r_status     <= n_status;
        r_res_cnt    <= n_res_cnt;
        r_res_end    <= n_res_end;
        r_m          <= n_m;
        r_iter       <= n_iter;
        r_prod       <= n_prod;
        if (out_load) begin
            r_o_banned  <= (r_res_end > {1'b0, r_now});
            r_o_cnt     <= r_res_cnt;
            r_o_end     <= r_res_end;
            r_o_removed <= r_removed;
            r_o_status  <= r_status;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // Checks.
    `PPBT_ASSERT(a_busy_after_accept, i_in.valid && i_in.ready |=> !i_in.ready,
                 "ready after accept")
    `PPBT_ASSERT(a_result_from_done, $rose(o_out.valid) |-> $past(r_state == ST_DONE),
                 "stray result")
    `PPBT_ASSERT(a_drop_fields_zero,
                 o_out.valid && o_out.status |-> !o_out.banned &&
                 (o_out.strike_count == '0) && (o_out.removed == '0),
                 "dropped strike fields")
    `PPBT_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out.valid && !i_in.ready, "reset state")

endmodule

`default_nettype wire

### bench/peer_penalty_ban_table_test.sv
// Self-checking bench for the peer penalty ban table: a short directed table, then random
// phases of strikes, queries, sweeps and unused commands under changing registers, checked against a model.
// Depends on ppbt_pkg, the channel interfaces of ppbt_ifs.sv and peer_penalty_ban_table.
`timescale 1ns / 1ps

module peer_penalty_ban_table_test;
    import ppbt_pkg::*;

    localparam int SLOTS = ENTRIES_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [NOW_W-1:0] NOW_MAX = '1;
    localparam int DRAIN_CYCLES = SLOTS + 40;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int POOL_MAX = 12;

    // One result beat as the table reports it.
    typedef struct packed {
        logic             banned;
        logic [CNT_W-1:0] strike_count;
        logic [END_W-1:0] ban_end_ms;
        logic [REM_W-1:0] removed;
        logic             status;
    } t_ban_verdict;

    // One row of the directed table: a register write or a command beat, with an
    // optional verdict typed in by hand.
    typedef struct packed {
        logic                  is_write;
        t_reg                  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [CMD_W-1:0]      cmd;
        logic [KEY_W-1:0]      key;
        logic [NOW_W-1:0]      now_ms;
        logic                  typed;
        t_ban_verdict          verdict;
    } t_step_row;

    logic i_clk;
    logic i_rst_n;

    ppbt_in_if  cmd_ch ();
    ppbt_out_if verdict_ch ();
    ppbt_cfg_if cfg_ch ();

    peer_penalty_ban_table #(.ENTRIES(SLOTS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (verdict_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of the registers and the table.
    logic [MIN_W-1:0] mdl_base;
    logic [MIN_W-1:0] mdl_max;
    logic [CNT_W-1:0] mdl_cap;
    logic             slot_used    [SLOTS];
    logic [KEY_W-1:0] slot_key     [SLOTS];
    logic [CNT_W-1:0] slot_strikes [SLOTS];
    logic [END_W-1:0] slot_end     [SLOTS];

    t_ban_verdict expected_verdicts [$];
    t_ban_verdict last_prediction;
    int           fault_count = 0;
    logic         calm = 1'b0;

    // Clock.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run limit, well above the slowest correct run.
    initial begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int find_peer(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // Applies one command to the shadow table and returns the verdict it should give.
    function automatic t_ban_verdict ban_table_apply(logic [CMD_W-1:0] cmd,
            logic [KEY_W-1:0] key, logic [NOW_W-1:0] now_ms);
        t_ban_verdict v;
        int           slot;
        logic [4:0]   count;
        logic [31:0]  minutes;
        logic [63:0]  sum;
        v = '0;
        case (cmd)
            CMD_STRIKE: begin
                slot = find_peer(key);
                // A new peer takes the lowest free slot, if there is one.
                for (int i = 0; i < SLOTS && slot < 0; i++) begin
                    if (!slot_used[i]) begin
                        slot = i;
                        slot_used[i] = 1'b1;
                        slot_key[i] = key;
                        slot_strikes[i] = '0;
                        slot_end[i] = '0;
                    end
                end
                if (slot < 0) begin
                    v.status = 1'b1;
                end else begin
                    count = {1'b0, slot_strikes[slot]} + 5'd1;
                    if (count > {1'b0, mdl_cap})
                        count = {1'b0, mdl_cap};
                    // Base length, doubled per strike after the first, each doubling capped.
                    minutes = {16'd0, mdl_base};
                    for (int i = 1; i < count; i++) begin
                        minutes = minutes * 2;
                        if (minutes > {16'd0, mdl_max})
                            minutes = {16'd0, mdl_max};
                    end
                    sum = 64'(now_ms) + 64'(minutes) * 64'(MS_PER_MIN);
                    slot_strikes[slot] = count[CNT_W-1:0];
                    slot_end[slot] = sum[END_W-1:0];
                    v.strike_count = count[CNT_W-1:0];
                    v.ban_end_ms = slot_end[slot];
                    v.banned = slot_end[slot] > {1'b0, now_ms};
                end
            end
            CMD_QUERY: begin
                slot = find_peer(key);
                if (slot >= 0) begin
                    v.strike_count = slot_strikes[slot];
                    v.ban_end_ms = slot_end[slot];
                    v.banned = slot_end[slot] > {1'b0, now_ms};
                end
            end
            CMD_SWEEP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && slot_end[i] <= {1'b0, now_ms}) begin
                        slot_used[i] = 1'b0;
                        if (v.removed != REM_SAT)
                            v.removed = v.removed + REM_W'(1);
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_step_row cmd_row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
            logic [NOW_W-1:0] now_ms);
        t_step_row r;
        r = '0;
        r.cmd = cmd;
        r.key = key;
        r.now_ms = now_ms;
        return r;
    endfunction

    function automatic t_step_row typed_row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
            logic [NOW_W-1:0] now_ms, t_ban_verdict v);
        t_step_row r;
        r = cmd_row(cmd, key, now_ms);
        r.typed = 1'b1;
        r.verdict = v;
        return r;
    endfunction

    function automatic t_step_row write_row(t_reg idx, logic [CFG_DATA_W-1:0] data);
        t_step_row r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_data = data;
        return r;
    endfunction

    // Keeps the command valid low for the given number of cycles.
    task automatic hold_off(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Presents one command beat and records its verdict once the table takes it.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
            logic [NOW_W-1:0] now_ms, logic typed, t_ban_verdict typed_verdict);
        @(negedge i_clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= cmd;
        cmd_ch.peer_key <= key;
        cmd_ch.now_ms <= now_ms;
        do @(posedge i_clk); while (!cmd_ch.ready);
        last_prediction = ban_table_apply(cmd, key, now_ms);
        expected_verdicts.push_back(typed ? typed_verdict : last_prediction);
    endtask

    // Lowers the command valid and waits until every verdict has come back.
    task automatic drain();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(t_reg idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_BASE: mdl_base = data;
            REG_MAX:  mdl_max = data;
            REG_CAP:  mdl_cap = data[CNT_W-1:0];
            default:  ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls on ready, changed at the falling edge.
    initial begin
        int stall;
        stall = 0;
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                verdict_ch.ready <= 1'b0;
                stall--;
            end else begin
                verdict_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fault_count++;
        end
    endfunction

    // Each result beat is compared with the oldest outstanding verdict.
    always @(posedge i_clk) begin : verdict_monitor
        t_ban_verdict got;
        t_ban_verdict want;
        if (verdict_ch.valid && verdict_ch.ready) begin
            got.banned = verdict_ch.banned;
            got.strike_count = verdict_ch.strike_count;
            got.ban_end_ms = verdict_ch.ban_end_ms;
            got.removed = verdict_ch.removed;
            got.status = verdict_ch.status;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result beat with none outstanding, expected nothing, got %p",
                         $time, got);
                fault_count++;
            end else begin
                want = expected_verdicts.pop_front();
                check_field("banned", 64'(want.banned), 64'(got.banned));
                check_field("strike_count", 64'(want.strike_count), 64'(got.strike_count));
                check_field("ban_end_ms", 64'(want.ban_end_ms), 64'(got.ban_end_ms));
                check_field("removed", 64'(want.removed), 64'(got.removed));
                check_field("status", 64'(want.status), 64'(got.status));
            end
        end
    end

    // Stimulus.
    initial begin
        t_step_row        dir_rows [$];
        logic [KEY_W-1:0] peer_pool [POOL_MAX];
        logic [MIN_W-1:0] phase_base [PHASES];
        logic [MIN_W-1:0] phase_max [PHASES];
        logic [CNT_W-1:0] phase_cap [PHASES];
        logic [NOW_W-1:0] clock_ms;
        logic [KEY_W-1:0] key;
        logic [CMD_W-1:0] cmd;
        int               roll;
        int               fill_at;
        int               full_hits;
        int               pool_n;

        // Known levels on every input, shadow state at its reset values.
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_STRIKE;
        cmd_ch.peer_key = '0;
        cmd_ch.now_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.idx = REG_BASE;
        cfg_ch.data = '0;
        mdl_base = BASE_RST;
        mdl_max = MAX_RST;
        mdl_cap = CAP_RST;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, starting from the reset registers.
        dir_rows.push_back(typed_row(CMD_QUERY, 64'h0123_4567_89AB_CDEF, '0, '0));
        dir_rows.push_back(typed_row(CMD_SWEEP, '0, '0, '0));
        dir_rows.push_back(typed_row(CMD_UNUSED, 64'h0123_4567_89AB_CDEF, 48'd123, '0));
        dir_rows.push_back(typed_row(CMD_STRIKE, '0, '0,
                                     t_ban_verdict'{1'b1, 4'd1, 49'd300000, 7'd0, 1'b0}));
        dir_rows.push_back(cmd_row(CMD_STRIKE, '0, '0));
        // Ban end equal to now is not banned.
        dir_rows.push_back(cmd_row(CMD_QUERY, '0, 48'd600000));
        dir_rows.push_back(cmd_row(CMD_STRIKE, KEY_ONES, NOW_MAX));
        dir_rows.push_back(cmd_row(CMD_QUERY, KEY_ONES, NOW_MAX));
        dir_rows.push_back(cmd_row(CMD_SWEEP, 64'hFEDC_BA98_7654_3210, NOW_MAX));
        dir_rows.push_back(typed_row(CMD_QUERY, '0, '0, '0));
        // First strike uses the base even above the cap; later doublings are capped.
        dir_rows.push_back(write_row(REG_BASE, 16'hFFFF));
        dir_rows.push_back(write_row(REG_MAX, 16'd1));
        dir_rows.push_back(write_row(REG_CAP, 16'd15));
        dir_rows.push_back(cmd_row(CMD_STRIKE, 64'h0123_4567_89AB_CDEF, 48'd1000));
        dir_rows.push_back(cmd_row(CMD_STRIKE, 64'h0123_4567_89AB_CDEF, 48'd1000));
        dir_rows.push_back(cmd_row(CMD_STRIKE, 64'h0123_4567_89AB_CDEF, 48'd2000));
        // Lowered strike cap pulls the count down on the next strike.
        dir_rows.push_back(write_row(REG_CAP, 16'd1));
        dir_rows.push_back(cmd_row(CMD_STRIKE, 64'h0123_4567_89AB_CDEF, 48'd5000));
        // Zero base and zero cap: count 0, ban end equal to now.
        dir_rows.push_back(write_row(REG_BASE, 16'd0));
        dir_rows.push_back(write_row(REG_CAP, 16'd0));
        dir_rows.push_back(cmd_row(CMD_STRIKE, 64'hFEDC_BA98_7654_3210, 48'd7));
        dir_rows.push_back(cmd_row(CMD_QUERY, 64'hFEDC_BA98_7654_3210, 48'd7));
        dir_rows.push_back(cmd_row(CMD_SWEEP, '0, 48'd7));
        dir_rows.push_back(write_row(REG_MAX, 16'hFFFF));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_write) begin
                drain();
                write_register(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end else begin
                hold_off(pick_gap());
                send_command(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].now_ms,
                             dir_rows[i].typed, dir_rows[i].verdict);
            end
        end

        // Register settings of the random phases, extremes first.
        phase_base[0] = BASE_RST;  phase_max[0] = MAX_RST;  phase_cap[0] = CAP_RST;
        phase_base[1] = 16'd1;     phase_max[1] = 16'd1;    phase_cap[1] = 4'd1;
        phase_base[2] = 16'hFFFF;  phase_max[2] = 16'hFFFF; phase_cap[2] = 4'd15;
        phase_base[3] = 16'hFFFF;  phase_max[3] = 16'd1;    phase_cap[3] = 4'd15;
        phase_base[4] = 16'd1;     phase_max[4] = 16'hFFFF; phase_cap[4] = 4'd15;
        phase_base[5] = 16'd3;     phase_max[5] = 16'd200;  phase_cap[5] = 4'd2;
        phase_base[6] = MIN_W'($urandom_range(1, 30));
        phase_max[6] = MIN_W'($urandom_range(1, 65535));
        phase_cap[6] = CNT_W'($urandom_range(1, 15));
        phase_base[7] = MIN_W'($urandom_range(1, 65535));
        phase_max[7] = MIN_W'($urandom_range(1, 65535));
        phase_cap[7] = CNT_W'($urandom_range(1, 15));

        foreach (peer_pool[i])
            peer_pool[i] = {$urandom, $urandom};

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_register(REG_BASE, phase_base[p]);
            write_register(REG_MAX, phase_max[p]);
            write_register(REG_CAP, 16'(phase_cap[p]));
            calm = ($urandom_range(0, 3) == 0);
            // Keep part of the peer set so entries carry over into the new settings.
            foreach (peer_pool[i])
                if ($urandom_range(0, 1) == 1)
                    peer_pool[i] = {$urandom, $urandom};
            pool_n = $urandom_range(3, POOL_MAX);
            clock_ms = ($urandom_range(0, 1) == 1) ? NOW_W'({$urandom, $urandom})
                                                   : NOW_W'($urandom_range(0, 100000));
            fill_at = (p == 0 || $urandom_range(0, 1) == 1)
                      ? $urandom_range(0, ITEMS_PER_PHASE - 1) : -1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Fill the table with fresh peers until strikes are dropped, then sweep it at the latest time.
                if (n == fill_at) begin
                    full_hits = 0;
                    while (full_hits < 2) begin
                        hold_off(pick_gap());
                        send_command(CMD_STRIKE, {$urandom, $urandom}, clock_ms, 1'b0, '0);
                        if (last_prediction.status)
                            full_hits++;
                    end
                    hold_off(pick_gap());
                    send_command(CMD_QUERY, peer_pool[0], clock_ms, 1'b0, '0);
                    hold_off(pick_gap());
                    send_command(CMD_SWEEP, '0, NOW_MAX, 1'b0, '0);
                end

                // Time mostly moves forward in small steps, sometimes jumps anywhere.
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    clock_ms = NOW_W'({$urandom, $urandom});
                else if (roll == 3)
                    clock_ms = NOW_MAX;
                else if (roll == 4)
                    clock_ms = '0;
                else if (roll < 80)
                    clock_ms = clock_ms + NOW_W'(64'($urandom) >> $urandom_range(12, 31));
                else
                    clock_ms = clock_ms + NOW_W'(64'($urandom) >> $urandom_range(0, 31));

                roll = $urandom_range(0, 99);
                if (roll < 85)
                    key = peer_pool[$urandom_range(0, pool_n - 1)];
                else if (roll < 95)
                    key = {$urandom, $urandom};
                else if (roll < 98)
                    key = '0;
                else
                    key = KEY_ONES;

                roll = $urandom_range(0, 99);
                if (roll < 45)
                    cmd = CMD_STRIKE;
                else if (roll < 75)
                    cmd = CMD_QUERY;
                else if (roll < 95)
                    cmd = CMD_SWEEP;
                else
                    cmd = CMD_UNUSED;

                hold_off(pick_gap());
                send_command(cmd, key, clock_ms, 1'b0, '0);
            end
        end

        // Let the last verdicts arrive, then watch for stray beats.
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
